@@ design/lrupin_pkg.sv @@
// Package for the LRU key cache with pinned entries.
// Holds the command codes, result status codes and sequencer states.
// No dependencies.
package lrupin_pkg;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_TOUCH  = 3'd2;
  localparam logic [2:0] CMD_PIN    = 3'd3;
  localparam logic [2:0] CMD_UNPIN  = 3'd4;

  typedef enum logic [2:0] {
    ST_HIT         = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_ALL_PINNED  = 3'd2,
    ST_REMOVED     = 3'd3,
    ST_NOT_PRESENT = 3'd4,
    ST_EVICTED     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_CHECK,
    S_VSCAN,
    S_VREAD,
    S_EVICT,
    S_INSERT
  } state_e;

endpackage

@@ design/lru_cache_with_pinned_entries_core.sv @@
// Top level of the LRU key cache with pinned entries.
// Depends on lrupin_pkg for command, status and state codes.
//
//   Channel | Signals                                            | Dir
//   input   | in_valid_i, in_ready_o, cmd_i, model_id_i,         | in
//           | model_version_i, load_pinned_i                     |
//   output  | out_valid_o, out_ready_i, status_o, slot_o,        | out
//           | victim_model_id_o, victim_version_o, last_o        |
//   config  | cfg_we_i, cfg_data_i (load limit)                  | in
//
// Every known command scans the key store one entry per cycle through the single key
// compare and the key memory read port, after the command is accepted in the idle state.
// A load miss adds a check state and, unless no unpinned victim is found, an insert state;
// each eviction adds a victim scan of the key store, a key read state and the eviction beat.
// Reset clears all valid bits, pin bits and ranks at once; no clearing pass.
// A stalled output beat holds the sequencer; the next input beat is taken while
// the final result beat still waits in the output register.
module lru_cache_with_pinned_entries_core #(
  parameter int CAPACITY = 8,
  parameter int ID_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] model_id_i,
  input  logic [31:0] model_version_i,
  input  logic        load_pinned_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  slot_o,
  output logic [15:0] victim_model_id_o,
  output logic [31:0] victim_version_o,
  output logic        last_o
);

  localparam int IdW   = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int SlotW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int LimW  = (CntW > 4) ? CntW : 4;

  lrupin_pkg::state_e state_q, state_d;

  logic [3:0]       lim_cfg_q;
  logic [LimW-1:0]  limit;

  logic [2:0]       cmd_q, cmd_d;
  logic [IdW-1:0]   key_id_q, key_id_d;
  logic [31:0]      key_ver_q, key_ver_d;
  logic             lp_q, lp_d;

  logic [SlotW-1:0] idx_q, idx_d;
  logic             found_q, found_d;
  logic [SlotW-1:0] hit_q, hit_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             free_ok_q, free_ok_d;
  logic [SlotW-1:0] free_q, free_d;
  logic             vfound_q, vfound_d;
  logic [SlotW-1:0] vic_q, vic_d;

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CAPACITY-1:0] pin_q, pin_d;
  logic [SlotW-1:0]    rank_q [CAPACITY];
  logic [SlotW-1:0]    rank_d [CAPACITY];

  logic [IdW-1:0]   mem_id  [CAPACITY];
  logic [31:0]      mem_ver [CAPACITY];
  logic [IdW-1:0]   rd_id_q;
  logic [31:0]      rd_ver_q;
  logic [SlotW-1:0] rd_addr;
  logic             mem_we;

  logic                out_valid_q;
  lrupin_pkg::status_e status_q;
  logic [2:0]          slot_q;
  logic [15:0]         vid_q;
  logic [31:0]         vver_q;
  logic                last_q;

  logic                out_load;
  lrupin_pkg::status_e out_status;
  logic [SlotW-1:0]    out_slot;
  logic [15:0]         out_vid;
  logic [31:0]         out_vver;
  logic                out_last;

  logic             op_front, op_drop, op_ins;
  logic [SlotW-1:0] op_idx;

  logic             out_free;
  logic             scan_last;
  logic             match_now;
  logic             found_now;
  logic [SlotW-1:0] hit_now;
  logic [CntW-1:0]  cnt_now;
  logic             cand_now;
  logic             vfound_now;
  logic [SlotW-1:0] vic_now;
  logic             is_miss;
  logic             over_limit;
  logic             evict_more;

  assign out_free   = !out_valid_q || out_ready_i;
  assign scan_last  = (idx_q == SlotW'(CAPACITY - 1));
  assign match_now  = valid_q[idx_q] && (rd_id_q == key_id_q) && (rd_ver_q == key_ver_q);
  assign found_now  = found_q || match_now;
  assign hit_now    = found_q ? hit_q : idx_q;
  assign cnt_now    = cnt_q + CntW'(valid_q[idx_q]);
  assign cand_now   = valid_q[idx_q] && !pin_q[idx_q] &&
                      (!vfound_q || (rank_q[idx_q] > rank_q[vic_q]));
  assign vfound_now = vfound_q || cand_now;
  assign vic_now    = cand_now ? idx_q : vic_q;
  assign is_miss    = (cmd_q == lrupin_pkg::CMD_LOAD) && !found_now;
  assign over_limit = (LimW'(cnt_q) >= limit);
  assign evict_more = (LimW'(CntW'(cnt_q - CntW'(1))) >= limit);

  always_comb begin
    if (lim_cfg_q == 4'd0) begin
      limit = LimW'(1);
    end else if (LimW'(lim_cfg_q) > LimW'(CAPACITY)) begin
      limit = LimW'(CAPACITY);
    end else begin
      limit = LimW'(lim_cfg_q);
    end
  end

  assign in_ready_o = (state_q == lrupin_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrupin_pkg::S_IDLE: begin
        if (in_valid_i && (cmd_i <= lrupin_pkg::CMD_UNPIN)) begin
          state_d = lrupin_pkg::S_FIND;
        end
      end
      lrupin_pkg::S_FIND: begin
        if (scan_last) begin
          if (is_miss) begin
            state_d = lrupin_pkg::S_CHECK;
          end else if (out_free) begin
            state_d = lrupin_pkg::S_IDLE;
          end
        end
      end
      lrupin_pkg::S_CHECK: begin
        state_d = over_limit ? lrupin_pkg::S_VSCAN : lrupin_pkg::S_INSERT;
      end
      lrupin_pkg::S_VSCAN: begin
        if (scan_last) begin
          if (vfound_now) begin
            state_d = lrupin_pkg::S_VREAD;
          end else if (out_free) begin
            state_d = lrupin_pkg::S_IDLE;
          end
        end
      end
      lrupin_pkg::S_VREAD: begin
        state_d = lrupin_pkg::S_EVICT;
      end
      lrupin_pkg::S_EVICT: begin
        if (out_free) begin
          state_d = evict_more ? lrupin_pkg::S_VSCAN : lrupin_pkg::S_INSERT;
        end
      end
      lrupin_pkg::S_INSERT: begin
        if (out_free) begin
          state_d = lrupin_pkg::S_IDLE;
        end
      end
      default: state_d = lrupin_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    logic [SlotW-1:0] op_rank;
    cmd_d      = cmd_q;
    key_id_d   = key_id_q;
    key_ver_d  = key_ver_q;
    lp_d       = lp_q;
    idx_d      = idx_q;
    found_d    = found_q;
    hit_d      = hit_q;
    cnt_d      = cnt_q;
    free_ok_d  = free_ok_q;
    free_d     = free_q;
    vfound_d   = vfound_q;
    vic_d      = vic_q;
    valid_d    = valid_q;
    pin_d      = pin_q;
    rank_d     = rank_q;
    out_load   = 1'b0;
    out_status = lrupin_pkg::ST_HIT;
    out_slot   = '0;
    out_vid    = '0;
    out_vver   = '0;
    out_last   = 1'b1;
    op_front   = 1'b0;
    op_drop    = 1'b0;
    op_ins     = 1'b0;
    op_idx     = idx_q;
    mem_we     = 1'b0;

    unique case (state_q)
      lrupin_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = cmd_i;
          key_id_d  = model_id_i[IdW-1:0];
          key_ver_d = model_version_i;
          lp_d      = load_pinned_i;
          idx_d     = '0;
          found_d   = 1'b0;
          cnt_d     = '0;
          free_ok_d = 1'b0;
        end
      end
      lrupin_pkg::S_FIND: begin
        cnt_d   = cnt_now;
        found_d = found_now;
        hit_d   = hit_now;
        if (!free_ok_q && !valid_q[idx_q]) begin
          free_ok_d = 1'b1;
          free_d    = idx_q;
        end
        if (!scan_last) begin
          idx_d = idx_q + SlotW'(1);
        end else if (!is_miss && out_free) begin
          out_load = 1'b1;
          op_idx   = hit_now;
          out_slot = hit_now;
          if (!found_now) begin
            out_status = lrupin_pkg::ST_NOT_PRESENT;
            out_slot   = '0;
          end else if (cmd_q == lrupin_pkg::CMD_REMOVE) begin
            out_status = lrupin_pkg::ST_REMOVED;
            op_drop    = 1'b1;
          end else if (cmd_q == lrupin_pkg::CMD_PIN) begin
            pin_d[hit_now] = 1'b1;
          end else if (cmd_q == lrupin_pkg::CMD_UNPIN) begin
            pin_d[hit_now] = 1'b0;
          end else begin
            op_front = 1'b1;
          end
        end
      end
      lrupin_pkg::S_CHECK: begin
        idx_d    = '0;
        vfound_d = 1'b0;
      end
      lrupin_pkg::S_VSCAN: begin
        vfound_d = vfound_now;
        vic_d    = vic_now;
        if (!scan_last) begin
          idx_d = idx_q + SlotW'(1);
        end else if (!vfound_now && out_free) begin
          out_load   = 1'b1;
          out_status = lrupin_pkg::ST_ALL_PINNED;
        end
      end
      lrupin_pkg::S_VREAD: begin
      end
      lrupin_pkg::S_EVICT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = lrupin_pkg::ST_EVICTED;
          out_slot   = vic_q;
          out_vid    = 16'(rd_id_q);
          out_vver   = rd_ver_q;
          out_last   = 1'b0;
          op_drop    = 1'b1;
          op_idx     = vic_q;
          cnt_d      = cnt_q - CntW'(1);
          if (!free_ok_q || (vic_q < free_q)) begin
            free_ok_d = 1'b1;
            free_d    = vic_q;
          end
          idx_d    = '0;
          vfound_d = 1'b0;
        end
      end
      lrupin_pkg::S_INSERT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = lrupin_pkg::ST_INSERTED;
          out_slot   = free_q;
          op_ins     = 1'b1;
          op_idx     = free_q;
          mem_we     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    op_rank = rank_q[op_idx];
    for (int i = 0; i < CAPACITY; i++) begin
      if (op_front && valid_q[i] && (rank_q[i] < op_rank)) begin
        rank_d[i] = rank_q[i] + SlotW'(1);
      end
      if (op_drop && valid_q[i] && (rank_q[i] > op_rank)) begin
        rank_d[i] = rank_q[i] - SlotW'(1);
      end
      if (op_ins && valid_q[i]) begin
        rank_d[i] = rank_q[i] + SlotW'(1);
      end
    end
    if (op_front) begin
      rank_d[op_idx] = '0;
    end
    if (op_drop) begin
      valid_d[op_idx] = 1'b0;
      pin_d[op_idx]   = 1'b0;
      rank_d[op_idx]  = '0;
    end
    if (op_ins) begin
      valid_d[op_idx] = 1'b1;
      pin_d[op_idx]   = lp_q;
      rank_d[op_idx]  = '0;
    end
  end

  assign rd_addr = ((state_q == lrupin_pkg::S_VREAD) || (state_q == lrupin_pkg::S_EVICT)) ?
                   vic_q : idx_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_id[free_q]  <= key_id_q;
      mem_ver[free_q] <= key_ver_q;
    end
    rd_id_q  <= mem_id[rd_addr];
    rd_ver_q <= mem_ver[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lrupin_pkg::S_IDLE;
      lim_cfg_q    <= 4'd8;
      valid_q      <= '0;
      pin_q        <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      free_ok_q    <= 1'b0;
      vfound_q     <= 1'b0;
      idx_q        <= '0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        lim_cfg_q <= cfg_data_i;
      end
      valid_q   <= valid_d;
      pin_q     <= pin_d;
      rank_q    <= rank_d;
      found_q   <= found_d;
      free_ok_q <= free_ok_d;
      vfound_q  <= vfound_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_id_q  <= key_id_d;
    key_ver_q <= key_ver_d;
    lp_q      <= lp_d;
    hit_q     <= hit_d;
    free_q    <= free_d;
    vic_q     <= vic_d;
    if (out_load) begin
      status_q <= out_status;
      slot_q   <= 3'(out_slot);
      vid_q    <= out_vid;
      vver_q   <= out_vver;
      last_q   <= out_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign slot_o            = slot_q;
  assign victim_model_id_o = vid_q;
  assign victim_version_o  = vver_q;
  assign last_o            = last_q;

  a_pin_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pin_q & ~valid_q) == '0)
    else $error("pin bit set on an empty entry");

  a_victim_unpinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrupin_pkg::S_EVICT) |-> (valid_q[vic_q] && !pin_q[vic_q]))
    else $error("eviction of an empty or pinned entry");

  a_insert_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrupin_pkg::S_INSERT) |-> (free_ok_q && !valid_q[free_q]))
    else $error("insert without a free entry");

  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == lrupin_pkg::ST_EVICTED)) |-> !last_o)
    else $error("eviction beat marked as last");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (cmd_i <= lrupin_pkg::CMD_UNPIN)) |=>
      ((state_q == lrupin_pkg::S_FIND) && (idx_q == '0)))
    else $error("accepted command did not start a key scan");

endmodule
